// ----- sv/oci_pkg.sv -----
package oci_pkg;

	// operation codes carried in the low bits of the input item
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} st_t;

	// control that travels with each item down the pipeline
	typedef struct packed {
		logic       valid;
		logic [2:0] op;
		logic       sgn;
		logic       neg;
		st_t        st;
	} ctl_t;

endpackage

// ----- sv/oci_prep.sv -----
module oci_prep #(
	parameter int W = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid,
	input  logic [2:0]      op,
	input  logic [W-1:0]    a,
	input  logic [W-1:0]    b,
	input  logic            sgn,
	output oci_pkg::ctl_t   ctl_s1,
	output logic [W-1:0]    ma_s1,
	output logic [W-1:0]    mb_s1,
	output logic [W-1:0]    r_s1
);
	import oci_pkg::*;

	localparam logic [W-1:0] SB = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] M  = {W{1'b1}};

	logic         na, nb;
	logic [W:0]   sum;
	logic [W-1:0] dif;
	logic [W-1:0] r;
	st_t          st;

	assign na  = a[W-1];
	assign nb  = b[W-1];
	assign sum = {1'b0, a} + {1'b0, b};
	assign dif = a - b;

	// add, subtract and negate finish here; divide flags its special cases
	always_comb begin
		r  = '0;
		st = ST_OK;
		case (op)
			OP_ADD: begin
				r = sum[W-1:0];
				if (sgn ? (na == nb && sum[W-1] != na) : sum[W])
					st = ST_OVF;
			end
			OP_SUB: begin
				r = dif;
				if (sgn ? (na != nb && dif[W-1] != na) : (a < b))
					st = ST_OVF;
			end
			OP_DIV: begin
				if (b == '0)
					st = ST_DIV0;
				else if (sgn && a == SB && b == M)
					st = ST_OVF;
			end
			OP_NEG: begin
				r = '0 - a;
				if (sgn ? (a == SB) : (a != '0))
					st = ST_OVF;
			end
			default: begin
				r  = '0;
				st = ST_OK;
			end
		endcase
	end

	// register stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= valid;
			ctl_s1.op    <= op;
			ctl_s1.sgn   <= sgn;
			ctl_s1.neg   <= sgn && (na != nb);
			ctl_s1.st    <= st;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= (sgn && na) ? ('0 - a) : a;
			mb_s1 <= (sgn && nb) ? ('0 - b) : b;
			r_s1  <= r;
		end
	end

endmodule

// ----- sv/oci_mul.sv -----
module oci_mul #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         en,
	input  logic         sgn,
	input  logic         neg,
	input  logic [W-1:0] ma,
	input  logic [W-1:0] mb,
	output logic [W-1:0] r_s4,
	output logic         ovf_s4
);
	localparam int HW = (W + 1) / 2;
	localparam int PW = 2 * HW;
	localparam int QW = 4 * HW;
	localparam logic [W-1:0] SB = {1'b1, {(W-1){1'b0}}};

	logic [PW-1:0] xe, ye;
	logic [PW-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [PW-1:0] ll_s2, hh_s2;
	logic [PW:0]   mid_s2;
	logic [2*W-1:0] prod_s3;
	logic [QW-1:0] prod_w;
	logic          sgn_s1, sgn_s2, sgn_s3;
	logic          neg_s1, neg_s2, neg_s3;
	logic [W-1:0]  lo, hi;
	logic          negr;

	assign xe = PW'(ma);
	assign ye = PW'(mb);
	assign prod_w = QW'(ll_s2) + (QW'(mid_s2) << HW) + (QW'(hh_s2) << PW);
	assign lo   = prod_s3[W-1:0];
	assign hi   = prod_s3[2*W-1:W];
	assign negr = neg_s3 && (prod_s3 != '0);

	// partial products, sum of cross terms, full product, then range check
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= PW'(xe[HW-1:0]) * PW'(ye[HW-1:0]);
			lh_s1  <= PW'(xe[HW-1:0]) * PW'(ye[PW-1:HW]);
			hl_s1  <= PW'(xe[PW-1:HW]) * PW'(ye[HW-1:0]);
			hh_s1  <= PW'(xe[PW-1:HW]) * PW'(ye[PW-1:HW]);
			sgn_s1 <= sgn;
			neg_s1 <= neg;

			ll_s2  <= ll_s1;
			hh_s2  <= hh_s1;
			mid_s2 <= {1'b0, lh_s1} + {1'b0, hl_s1};
			sgn_s2 <= sgn_s1;
			neg_s2 <= neg_s1;

			prod_s3 <= prod_w[2*W-1:0];
			sgn_s3  <= sgn_s2;
			neg_s3  <= neg_s2;

			r_s4 <= negr ? ('0 - lo) : lo;
			if (sgn_s3)
				ovf_s4 <= (hi != '0) || (lo > (negr ? SB : SB - 1'b1));
			else
				ovf_s4 <= (hi != '0);
		end
	end

endmodule

// ----- sv/oci_div_step.sv -----
module oci_div_step #(
	parameter int W = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  oci_pkg::ctl_t   ctl_in,
	input  logic [2*W-1:0]  pr_in,
	input  logic [W-1:0]    dv_in,
	input  logic [W-1:0]    side_in,
	output oci_pkg::ctl_t   ctl_q,
	output logic [2*W-1:0]  pr_q,
	output logic [W-1:0]    dv_q,
	output logic [W-1:0]    side_q
);
	import oci_pkg::*;

	logic [W:0]   cand;
	logic [W:0]   diff;
	logic         take;

	// shift in the next dividend bit and try the divisor against it
	assign cand = pr_in[2*W-1:W-1];
	assign take = cand >= {1'b0, dv_in};
	assign diff = cand - {1'b0, dv_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_q   <= {(take ? diff[W-1:0] : cand[W-1:0]), pr_in[W-2:0], take};
			dv_q   <= dv_in;
			side_q <= side_in;
		end
	end

endmodule

// ----- sv/overflow_checked_integer_alu.sv -----
// Overflow-checked integer ALU.
// Input items arrive on s_axis: an operation code (add, subtract, multiply,
// divide, negate) and two operands, of which the low WIDTH bits are used.
// Each item yields one result item on m_axis: the result value and a status
// (ok, overflow, divide by zero); the value is zero whenever status is not ok.
// cfg_we / cfg_wdata write signed_mode (1 two's complement, 0 unsigned);
// write it only while no item is in flight.
// The pipeline holds one prepare stage, one restoring divide stage per
// quotient bit, and one result stage; the multiplier runs in four stages
// alongside the divider chain and is delayed to line up with it.
// Throughput is one item per cycle unless the output stalls. All stages
// advance together, so when m_axis_tready is low with a result waiting, the
// whole pipeline holds and s_axis_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets signed_mode to 1.
module overflow_checked_integer_alu #(
	parameter int WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // mode[2:0], operand_a[66:3], operand_b[130:67]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata   // result_value[63:0], status[65:64]
);
	import oci_pkg::*;

	localparam int W  = WIDTH;
	localparam int MD = W - 4;

	logic         en;
	logic         signed_mode_q;
	ctl_t         ctl_c [W+1];
	logic [2*W-1:0] pr_c [W+1];
	logic [W-1:0] dv_c [W+1];
	logic [W-1:0] side_c [W+1];
	logic [W-1:0] ma_s1, mb_s1;
	logic [W-1:0] mul_r;
	logic         mul_ovf;
	logic [W-1:0] mul_r_dly_q [MD];
	logic         mul_ovf_dly_q [MD];
	ctl_t         ce;
	logic [W-1:0] q;
	logic [W-1:0] r_f;
	st_t          st_f;
	logic         out_valid_q;
	logic [W-1:0] out_r_q;
	st_t          out_st_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b1;
		end else if (cfg_we) begin
			signed_mode_q <= cfg_wdata;
		end
	end

	oci_prep #(.W(W)) u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.valid  (s_axis_tvalid),
		.op     (s_axis_tdata[2:0]),
		.a      (s_axis_tdata[3 +: W]),
		.b      (s_axis_tdata[67 +: W]),
		.sgn    (signed_mode_q),
		.ctl_s1 (ctl_c[0]),
		.ma_s1  (ma_s1),
		.mb_s1  (mb_s1),
		.r_s1   (side_c[0])
	);

	assign pr_c[0] = {{W{1'b0}}, ma_s1};
	assign dv_c[0] = mb_s1;

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < W; k++) begin : g_div
		oci_div_step #(.W(W)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_c[k]),
			.pr_in   (pr_c[k]),
			.dv_in   (dv_c[k]),
			.side_in (side_c[k]),
			.ctl_q   (ctl_c[k+1]),
			.pr_q    (pr_c[k+1]),
			.dv_q    (dv_c[k+1]),
			.side_q  (side_c[k+1])
		);
	end

	oci_mul #(.W(W)) u_mul (
		.clk    (clk),
		.en     (en),
		.sgn    (ctl_c[0].sgn),
		.neg    (ctl_c[0].neg),
		.ma     (ma_s1),
		.mb     (mb_s1),
		.r_s4   (mul_r),
		.ovf_s4 (mul_ovf)
	);

	// delay the product to meet the end of the divider chain
	always_ff @(posedge clk) begin
		if (en) begin
			mul_r_dly_q[0]   <= mul_r;
			mul_ovf_dly_q[0] <= mul_ovf;
			for (int i = 1; i < MD; i++) begin
				mul_r_dly_q[i]   <= mul_r_dly_q[i-1];
				mul_ovf_dly_q[i] <= mul_ovf_dly_q[i-1];
			end
		end
	end

	// pick the result for the operation and zero it on any fault
	assign ce = ctl_c[W];
	assign q  = pr_c[W][W-1:0];

	always_comb begin
		r_f  = side_c[W];
		st_f = ce.st;
		case (ce.op)
			OP_MUL: begin
				r_f  = mul_r_dly_q[MD-1];
				st_f = mul_ovf_dly_q[MD-1] ? ST_OVF : ST_OK;
			end
			OP_DIV: begin
				r_f = ce.neg ? ('0 - q) : q;
			end
			default: begin
				r_f  = side_c[W];
				st_f = ce.st;
			end
		endcase
		if (st_f != ST_OK)
			r_f = '0;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ce.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_r_q  <= r_f;
			out_st_q <= st_f;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_st_q, 64'(out_r_q)};

	// a faulted result carries a zero value
	a_zero_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q != ST_OK |-> out_r_q == '0)
		else $error("nonzero result with fault status");

	// the pipeline holds while a result waits
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> $stable(ctl_c[W]) && $stable(ctl_c[0]))
		else $error("pipeline moved during stall");

	// divide by zero only comes from a divide
	a_div0_src: assert property (@(posedge clk) disable iff (!arst_n)
		ce.valid && en && st_f == ST_DIV0 |-> ce.op == OP_DIV)
		else $error("divide by zero status on other operation");

endmodule

// ----- tb/overflow_checked_integer_alu_tb.sv -----
`timescale 1ns / 1ps

module overflow_checked_integer_alu_tb;
	import oci_pkg::*;

	localparam int WIDTH = 64;
	localparam int LATENCY = WIDTH + 2;
	localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL1 = '1;

	typedef struct {
		logic [63:0] value;
		st_t         st;
	} alu_result_t;

	// holds expected ALU results and checks the returned ones
	class alu_scoreboard;
		alu_result_t pending[$];
		bit          mode_signed = 1'b1;
		int          errors = 0;

		function alu_result_t compute(logic [2:0] op, logic [63:0] a, logic [63:0] b);
			alu_result_t res;
			logic [127:0] prod;
			logic [63:0]  ma, mb, q;
			logic         na, nb, neg;
			logic [64:0]  s;
			res.value = '0;
			res.st = ST_OK;
			na = a[63];
			nb = b[63];
			ma = (mode_signed && na) ? -a : a;
			mb = (mode_signed && nb) ? -b : b;
			case (op)
				OP_ADD: begin
					s = {1'b0, a} + {1'b0, b};
					res.value = s[63:0];
					if (mode_signed ? (na == nb && s[63] != na) : s[64])
						res.st = ST_OVF;
				end
				OP_SUB: begin
					res.value = a - b;
					if (mode_signed ? (na != nb && res.value[63] != na) : (a < b))
						res.st = ST_OVF;
				end
				OP_MUL: begin
					prod = {64'd0, ma} * {64'd0, mb};
					if (mode_signed) begin
						neg = (na != nb) && (prod != 0);
						if (prod[127:64] != 0 || prod[63:0] > (neg ? MINV : MINV - 1))
							res.st = ST_OVF;
						else
							res.value = neg ? -prod[63:0] : prod[63:0];
					end else if (prod[127:64] != 0) begin
						res.st = ST_OVF;
					end else begin
						res.value = prod[63:0];
					end
				end
				OP_DIV: begin
					if (b == 0) begin
						res.st = ST_DIV0;
					end else if (mode_signed && a == MINV && b == ALL1) begin
						res.st = ST_OVF;
					end else begin
						q = ma / mb;
						res.value = (mode_signed && na != nb) ? -q : q;
					end
				end
				OP_NEG: begin
					if (mode_signed ? (a == MINV) : (a != 0))
						res.st = ST_OVF;
					else
						res.value = -a;
				end
				default: ;
			endcase
			if (res.st != ST_OK)
				res.value = '0;
			return res;
		endfunction

		function void note_input(logic [2:0] op, logic [63:0] a, logic [63:0] b);
			pending.push_back(compute(op, a, b));
		endfunction

		function void check_result(logic [71:0] data);
			alu_result_t exp_res;
			if (pending.size() == 0) begin
				$error("result with nothing expected: %h", data);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (data[63:0] !== exp_res.value) begin
				$error("result_value: expected %h, actual %h", exp_res.value, data[63:0]);
				errors++;
			end
			if (data[65:64] !== exp_res.st) begin
				$error("status: expected %0d, actual %0d", exp_res.st, data[65:64]);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_wdata = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;

	alu_scoreboard sb = new();
	bit calm = 1'b0;

	overflow_checked_integer_alu #(.WIDTH(WIDTH)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random stall on the result side; none during the calm stretch
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 8);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// valid stays high after an accept until the next item or idle cycle drives it
	task automatic send_op(logic [2:0] op, logic [63:0] a, logic [63:0] b);
		while (!calm && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, b, a, op};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(op, a, b);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_signed(bit v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode_signed = v;
	endtask

	function automatic logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = v & 64'hFF;
			1: v = v & 64'hFFFF_FFFF;
			2: v = -(v & 64'hFFFF);
			3: v = $urandom_range(1) ? MINV : MINV - 1;
			4: v = $urandom_range(2) == 0 ? 64'd0 : ALL1;
			default: ;
		endcase
		return v;
	endfunction

	task automatic directed();
		logic [2:0] op;
		send_op(OP_ADD, MINV - 1, 64'd1);
		send_op(OP_ADD, ALL1, ALL1);
		send_op(OP_ADD, MINV, ALL1);
		send_op(OP_SUB, 64'd0, 64'd1);
		send_op(OP_SUB, MINV, 64'd1);
		send_op(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
		send_op(OP_MUL, MINV, ALL1);
		send_op(OP_MUL, 64'h4000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE);
		send_op(OP_MUL, ALL1, 64'd1);
		send_op(OP_DIV, 64'd7, 64'd0);
		send_op(OP_DIV, MINV, ALL1);
		send_op(OP_DIV, -64'sd7, 64'd2);
		send_op(OP_DIV, ALL1, 64'd3);
		send_op(OP_NEG, MINV, ALL1);
		send_op(OP_NEG, 64'd0, 64'd5);
		send_op(OP_NEG, 64'd1, 64'd0);
		for (op = 3'd5; op != 3'd0; op++)
			send_op(op, ALL1, ALL1);
	endtask

	task automatic random_ops(int n);
		logic [2:0] op;
		repeat (n) begin
			op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4));
			send_op(op, rand_operand(), rand_operand());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		random_ops(400);
		set_signed(1'b0);
		directed();
		random_ops(400);
		// hold off the sender until all results are back
		drain();
		calm = 1'b1;
		random_ops(300);
		calm = 1'b0;
		set_signed(1'b1);
		random_ops(300);
		set_signed(1'b0);
		random_ops(300);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
